// File: rtl/mwa_pkg.sv
// Shared widths, lane layout and register map of the multichannel window averager.
package mwa_pkg;

  localparam int NUM_LANES   = 10;
  localparam int SUM_W       = 22;
  localparam int CNT_W       = 6;
  localparam int BIT_CNT_W   = $clog2(SUM_W);
  localparam int FIELD_W     = 16;
  localparam int FAN_STEP_W  = 8;
  localparam int STAMP_W     = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int MAX_WINDOW  = 32;

  localparam logic [CNT_W-1:0]     RESET_WINDOW = CNT_W'(30);
  localparam logic [CNT_W-1:0]     MAX_LEN      = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0]     MIN_LEN      = CNT_W'(1);
  localparam logic                 REG_WINDOW   = 1'b0;
  localparam logic [NUM_LANES-1:0] LANE_SIGNED  = 10'b00_1111_1111;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(SUM_W - 1);

  typedef logic [SUM_W-1:0]                 sum_t;
  typedef logic [NUM_LANES-1:0][SUM_W-1:0]  lanes_t;

endpackage

// File: rtl/mwa_acc.sv
// Bit-serial accumulator: ten running channel sums updated one bit per cycle.
module mwa_acc (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  mwa_pkg::lanes_t op_i,
  input  logic            clear_i,
  output logic            busy_o,
  output mwa_pkg::lanes_t sum_o
);

  mwa_pkg::lanes_t                    sum_q;
  mwa_pkg::lanes_t                    op_q;
  logic [mwa_pkg::NUM_LANES-1:0]      carry_q;
  logic [mwa_pkg::NUM_LANES-1:0]      carry_d;
  logic [mwa_pkg::NUM_LANES-1:0]      bit_d;
  logic [mwa_pkg::BIT_CNT_W-1:0]      cnt_q;
  logic                               busy_q;

  always_comb begin
    for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
      bit_d[l]   = sum_q[l][0] ^ op_q[l][0] ^ carry_q[l];
      carry_d[l] = (sum_q[l][0] & op_q[l][0]) | (sum_q[l][0] & carry_q[l]) |
                   (op_q[l][0] & carry_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      op_q    <= '0;
      carry_q <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        sum_q <= '0;
      end else if (busy_q) begin
        for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
          sum_q[l] <= {bit_d[l], sum_q[l][mwa_pkg::SUM_W-1:1]};
          op_q[l]  <= {1'b0, op_q[l][mwa_pkg::SUM_W-1:1]};
        end
        carry_q <= carry_d;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == mwa_pkg::LAST_BIT) begin
          busy_q <= 1'b0;
        end
      end
      if (load_i) begin
        op_q    <= op_i;
        carry_q <= '0;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign sum_o  = sum_q;

endmodule

// File: rtl/mwa_div.sv
// Bit-serial divider lanes: serial abs, restoring division, serial sign restore.
module mwa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  mwa_pkg::lanes_t           sum_i,
  input  logic [mwa_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output mwa_pkg::lanes_t           quot_o
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_ABS,
    P_DIV,
    P_SIGN
  } phase_e;

  phase_e                                          phase_q;
  mwa_pkg::lanes_t                                 m_q;
  logic [mwa_pkg::NUM_LANES-1:0]                   neg_q;
  logic [mwa_pkg::NUM_LANES-1:0]                   one_q;
  logic [mwa_pkg::NUM_LANES-1:0][mwa_pkg::CNT_W-1:0] r_q;
  logic [mwa_pkg::CNT_W-1:0]                       d_q;
  logic [mwa_pkg::BIT_CNT_W-1:0]                   cnt_q;

  logic [mwa_pkg::NUM_LANES-1:0]                   neg_bit_d;
  logic [mwa_pkg::NUM_LANES-1:0]                   ge_d;
  logic [mwa_pkg::NUM_LANES-1:0][mwa_pkg::CNT_W-1:0] r_d;

  function automatic logic [mwa_pkg::NUM_LANES-1:0] m_q_lsb(mwa_pkg::lanes_t m);
    logic [mwa_pkg::NUM_LANES-1:0] b;
    for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
      b[l] = m[l][0];
    end
    return b;
  endfunction

  always_comb begin
    logic [mwa_pkg::CNT_W:0] rp;
    logic [mwa_pkg::CNT_W:0] diff;
    for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
      neg_bit_d[l] = neg_q[l] ? (m_q[l][0] ^ one_q[l]) : m_q[l][0];
      rp           = {r_q[l], m_q[l][mwa_pkg::SUM_W-1]};
      diff         = rp - {1'b0, d_q};
      ge_d[l]      = rp >= {1'b0, d_q};
      r_d[l]       = ge_d[l] ? diff[mwa_pkg::CNT_W-1:0] : rp[mwa_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      m_q     <= '0;
      neg_q   <= '0;
      one_q   <= '0;
      r_q     <= '0;
      d_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            m_q   <= sum_i;
            d_q   <= divisor_i;
            one_q <= '0;
            r_q   <= '0;
            cnt_q <= '0;
            for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
              neg_q[l] <= mwa_pkg::LANE_SIGNED[l] & sum_i[l][mwa_pkg::SUM_W-1];
            end
            phase_q <= P_ABS;
          end
        end
        P_ABS, P_SIGN: begin
          for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
            m_q[l] <= {neg_bit_d[l], m_q[l][mwa_pkg::SUM_W-1:1]};
          end
          one_q <= one_q | m_q_lsb(m_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == mwa_pkg::LAST_BIT) begin
            cnt_q   <= '0;
            one_q   <= '0;
            phase_q <= (phase_q == P_ABS) ? P_DIV : P_IDLE;
          end
        end
        P_DIV: begin
          for (int l = 0; l < mwa_pkg::NUM_LANES; l++) begin
            m_q[l] <= {m_q[l][mwa_pkg::SUM_W-2:0], ge_d[l]};
          end
          r_q   <= r_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == mwa_pkg::LAST_BIT) begin
            cnt_q   <= '0;
            phase_q <= P_SIGN;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  assign busy_o = (phase_q != P_IDLE);
  assign quot_o = m_q;

endmodule

// File: rtl/multichannel_window_averager.sv
// Top level of the multichannel window averager: control, register port and result register.
//
// Collects ten-channel air-quality samples into non-overlapping windows of
// window_length samples (0 acts as 1, above 32 acts as 32) and emits one record
// of truncated per-channel means of the samples whose pm_fine is not negative,
// stamped with the window's first stamp; a window with no such sample gives -1
// on the signed channels and 0 on the fan channels. Channel sums are added bit
// serially, so a sample with a valid pm_fine reading occupies the block while
// its sums are added, and one with a negative pm_fine skips the adder. A sample
// that closes a window with at least one valid sample then runs the ten
// bit-serial divider lanes (serial abs, 22 quotient bits, serial sign, a
// hand-over step) and loads the result register; a window with no valid sample
// adds only the result register load. The result register lets the next item
// in while a record waits to be taken. window_length sits at byte address 0 of
// the register port and resets to 30.
module multichannel_window_averager (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [mwa_pkg::ADDR_W-1:0]              paddr,
  input  logic [mwa_pkg::DATA_W-1:0]              pwdata,
  output logic [mwa_pkg::DATA_W-1:0]              prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [mwa_pkg::STAMP_W-1:0]             stamp_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      pm_one_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      pm_fine_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      pm_four_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      pm_ten_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      humid_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      temper_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      voc_level_i,
  input  logic signed [mwa_pkg::FIELD_W-1:0]      nox_level_i,
  input  logic [mwa_pkg::FIELD_W-1:0]             fan_rev_i,
  input  logic [mwa_pkg::FAN_STEP_W-1:0]          fan_step_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [mwa_pkg::STAMP_W-1:0]             avg_stamp_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_pm_one_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_pm_fine_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_pm_four_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_pm_ten_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_humid_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_temper_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_voc_o,
  output logic signed [mwa_pkg::FIELD_W-1:0]      avg_nox_o,
  output logic [mwa_pkg::FIELD_W-1:0]             avg_fan_rev_o,
  output logic [mwa_pkg::FAN_STEP_W-1:0]          avg_fan_step_o
);

  localparam int SX = mwa_pkg::SUM_W - mwa_pkg::FIELD_W;
  localparam int ZF = mwa_pkg::SUM_W - mwa_pkg::FIELD_W;
  localparam int ZS = mwa_pkg::SUM_W - mwa_pkg::FAN_STEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                         state_q;
  logic [mwa_pkg::CNT_W-1:0]      wl_q;
  logic [mwa_pkg::CNT_W-1:0]      seen_q;
  logic [mwa_pkg::CNT_W-1:0]      good_q;
  logic [mwa_pkg::STAMP_W-1:0]    start_q;
  logic                           out_valid_q;
  logic [mwa_pkg::STAMP_W-1:0]    avg_stamp_q;
  logic [mwa_pkg::NUM_LANES-2:0][mwa_pkg::FIELD_W-1:0] mean_q;
  logic [mwa_pkg::FAN_STEP_W-1:0] step_mean_q;

  logic                           in_accept;
  logic                           in_good;
  logic                           out_free;
  logic                           cfg_write;
  logic [mwa_pkg::CNT_W-1:0]      eff_len;
  logic                           close_win;
  logic                           acc_load;
  logic                           acc_clear;
  logic                           acc_busy;
  logic                           div_start;
  logic                           div_busy;
  mwa_pkg::lanes_t                ops;
  mwa_pkg::lanes_t                sums;
  mwa_pkg::lanes_t                quots;

  assign pready     = 1'b1;
  assign prdata     = {{(mwa_pkg::DATA_W-mwa_pkg::CNT_W){1'b0}}, wl_q};
  assign cfg_write  = psel && penable && pwrite && (paddr[2] == mwa_pkg::REG_WINDOW)
                      && (paddr[1:0] == 2'b00);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_good    = !pm_fine_i[mwa_pkg::FIELD_W-1];
  assign out_free   = !out_valid_q || !out_stall_i;

  assign eff_len    = (wl_q == '0) ? mwa_pkg::MIN_LEN :
                      ((wl_q > mwa_pkg::MAX_LEN) ? mwa_pkg::MAX_LEN : wl_q);
  assign close_win  = (seen_q >= eff_len);

  assign acc_load   = in_accept && in_good;
  assign acc_clear  = (state_q == S_EMIT) && out_free;
  assign div_start  = (state_q == S_CHECK) && close_win && (good_q != '0);

  assign ops[0] = {{SX{pm_one_i[mwa_pkg::FIELD_W-1]}}, pm_one_i};
  assign ops[1] = {{SX{pm_fine_i[mwa_pkg::FIELD_W-1]}}, pm_fine_i};
  assign ops[2] = {{SX{pm_four_i[mwa_pkg::FIELD_W-1]}}, pm_four_i};
  assign ops[3] = {{SX{pm_ten_i[mwa_pkg::FIELD_W-1]}}, pm_ten_i};
  assign ops[4] = {{SX{humid_i[mwa_pkg::FIELD_W-1]}}, humid_i};
  assign ops[5] = {{SX{temper_i[mwa_pkg::FIELD_W-1]}}, temper_i};
  assign ops[6] = {{SX{voc_level_i[mwa_pkg::FIELD_W-1]}}, voc_level_i};
  assign ops[7] = {{SX{nox_level_i[mwa_pkg::FIELD_W-1]}}, nox_level_i};
  assign ops[8] = {{ZF{1'b0}}, fan_rev_i};
  assign ops[9] = {{ZS{1'b0}}, fan_step_i};

  mwa_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (acc_load),
    .op_i    (ops),
    .clear_i (acc_clear),
    .busy_o  (acc_busy),
    .sum_o   (sums)
  );

  mwa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (sums),
    .divisor_i (good_q),
    .busy_o    (div_busy),
    .quot_o    (quots)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= mwa_pkg::RESET_WINDOW;
      seen_q      <= '0;
      good_q      <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      avg_stamp_q <= '0;
      mean_q      <= '0;
      step_mean_q <= '0;
    end else begin
      if (cfg_write) begin
        wl_q <= pwdata[mwa_pkg::CNT_W-1:0];
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (seen_q == '0) begin
              start_q <= stamp_i;
            end
            seen_q <= seen_q + 1'b1;
            if (in_good) begin
              good_q  <= good_q + 1'b1;
              state_q <= S_ADD;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_ADD: begin
          if (!acc_busy) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!close_win) begin
            state_q <= S_IDLE;
          end else if (div_start) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            avg_stamp_q <= start_q;
            for (int l = 0; l < mwa_pkg::NUM_LANES - 1; l++) begin
              if (good_q == '0) begin
                mean_q[l] <= {mwa_pkg::FIELD_W{mwa_pkg::LANE_SIGNED[l]}};
              end else begin
                mean_q[l] <= quots[l][mwa_pkg::FIELD_W-1:0];
              end
            end
            if (good_q == '0) begin
              step_mean_q <= '0;
            end else begin
              step_mean_q <= quots[mwa_pkg::NUM_LANES-1][mwa_pkg::FAN_STEP_W-1:0];
            end
            seen_q  <= '0;
            good_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign avg_stamp_o    = avg_stamp_q;
  assign avg_pm_one_o   = mean_q[0];
  assign avg_pm_fine_o  = mean_q[1];
  assign avg_pm_four_o  = mean_q[2];
  assign avg_pm_ten_o   = mean_q[3];
  assign avg_humid_o    = mean_q[4];
  assign avg_temper_o   = mean_q[5];
  assign avg_voc_o      = mean_q[6];
  assign avg_nox_o      = mean_q[7];
  assign avg_fan_rev_o  = mean_q[8];
  assign avg_fan_step_o = step_mean_q;

endmodule

// File: dv/multichannel_window_averager_test.sv
// Self-checking testbench for the multichannel window averager.
module multichannel_window_averager_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SIGNED = mwa_pkg::NUM_LANES - 2;
  localparam int STAMP_W = mwa_pkg::STAMP_W;
  localparam int FIELD_W = mwa_pkg::FIELD_W;
  localparam int FAN_STEP_W = mwa_pkg::FAN_STEP_W;
  localparam int CNT_W = mwa_pkg::CNT_W;
  localparam int ADDR_W = mwa_pkg::ADDR_W;
  localparam int DATA_W = mwa_pkg::DATA_W;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 116;
  localparam int NUM_PHASES = 12;

  typedef struct packed {
    logic [STAMP_W-1:0]                   stamp;
    logic [NUM_SIGNED-1:0][FIELD_W-1:0]   chan;
    logic [FIELD_W-1:0]                   rev;
    logic [FAN_STEP_W-1:0]                step;
  } sample_t;

  class boxcar_means;
    logic [CNT_W-1:0]   length_reg;
    int unsigned        seen;
    int unsigned        good;
    logic [STAMP_W-1:0] start;
    longint             sums [NUM_SIGNED];
    longint             rev_sum;
    longint             step_sum;
    sample_t            due [$];
    int unsigned        mismatches;
    int unsigned        records;
    string              chan_name [NUM_SIGNED];

    function new();
      length_reg = mwa_pkg::RESET_WINDOW;
      start = '0;
      mismatches = 0;
      records = 0;
      chan_name = '{"avg_pm_one", "avg_pm_fine", "avg_pm_four", "avg_pm_ten",
                    "avg_humid", "avg_temper", "avg_voc", "avg_nox"};
      clear();
    endfunction

    function void clear();
      seen = 0;
      good = 0;
      foreach (sums[i]) sums[i] = 0;
      rev_sum = 0;
      step_sum = 0;
    endfunction

    function void take_sample(sample_t s);
      sample_t     r;
      int unsigned span;
      longint      cnt;
      if (seen == 0) begin
        clear();
        start = s.stamp;
      end
      seen++;
      if (!s.chan[1][FIELD_W-1]) begin
        for (int i = 0; i < NUM_SIGNED; i++) sums[i] += longint'($signed(s.chan[i]));
        rev_sum += longint'(s.rev);
        step_sum += longint'(s.step);
        good++;
      end
      span = length_reg;
      if (span == 0) span = 1;
      if (span > mwa_pkg::MAX_WINDOW) span = mwa_pkg::MAX_WINDOW;
      if (seen < span) return;
      cnt = longint'(good);
      r.stamp = start;
      for (int i = 0; i < NUM_SIGNED; i++) begin
        r.chan[i] = (good != 0) ? FIELD_W'(sums[i] / cnt) : '1;
      end
      r.rev = (good != 0) ? FIELD_W'(rev_sum / cnt) : '0;
      r.step = (good != 0) ? FAN_STEP_W'(step_sum / cnt) : '0;
      due.push_back(r);
      clear();
    endfunction

    function void report(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endfunction

    function void match_mean(sample_t got);
      sample_t want;
      if (due.size() == 0) begin
        mismatches++;
        $display("%0t: record with none due, expected nothing actual stamp %h",
                 $time, got.stamp);
        return;
      end
      want = due.pop_front();
      records++;
      if (got.stamp !== want.stamp) report("avg_stamp", want.stamp, got.stamp);
      for (int i = 0; i < NUM_SIGNED; i++) begin
        if (got.chan[i] !== want.chan[i]) report(chan_name[i], want.chan[i], got.chan[i]);
      end
      if (got.rev !== want.rev) report("avg_fan_rev", want.rev, got.rev);
      if (got.step !== want.step) report("avg_fan_step", want.step, got.step);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [STAMP_W-1:0]            stamp_i = '0;
  logic signed [FIELD_W-1:0]     pm_one_i = '0;
  logic signed [FIELD_W-1:0]     pm_fine_i = '0;
  logic signed [FIELD_W-1:0]     pm_four_i = '0;
  logic signed [FIELD_W-1:0]     pm_ten_i = '0;
  logic signed [FIELD_W-1:0]     humid_i = '0;
  logic signed [FIELD_W-1:0]     temper_i = '0;
  logic signed [FIELD_W-1:0]     voc_level_i = '0;
  logic signed [FIELD_W-1:0]     nox_level_i = '0;
  logic [FIELD_W-1:0]            fan_rev_i = '0;
  logic [FAN_STEP_W-1:0]         fan_step_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [STAMP_W-1:0]            avg_stamp_o;
  logic signed [FIELD_W-1:0]     avg_pm_one_o;
  logic signed [FIELD_W-1:0]     avg_pm_fine_o;
  logic signed [FIELD_W-1:0]     avg_pm_four_o;
  logic signed [FIELD_W-1:0]     avg_pm_ten_o;
  logic signed [FIELD_W-1:0]     avg_humid_o;
  logic signed [FIELD_W-1:0]     avg_temper_o;
  logic signed [FIELD_W-1:0]     avg_voc_o;
  logic signed [FIELD_W-1:0]     avg_nox_o;
  logic [FIELD_W-1:0]            avg_fan_rev_o;
  logic [FAN_STEP_W-1:0]         avg_fan_step_o;

  boxcar_means board = new();
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  bit          hold_go = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;

  multichannel_window_averager i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("multichannel_window_averager_test NOT OK");
    $finish;
  end

  initial begin : drain
    sample_t got;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.stamp = avg_stamp_o;
        got.chan = {avg_nox_o, avg_voc_o, avg_temper_o, avg_humid_o,
                    avg_pm_ten_o, avg_pm_four_o, avg_pm_fine_o, avg_pm_one_o};
        got.rev = avg_fan_rev_o;
        got.step = avg_fan_step_o;
        board.match_mean(got);
      end
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  function automatic logic [FIELD_W-1:0] pick16();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  function automatic sample_t fill(logic [STAMP_W-1:0] stamp, logic [FIELD_W-1:0] value,
                                   logic [FIELD_W-1:0] fine, logic [FIELD_W-1:0] rev,
                                   logic [FAN_STEP_W-1:0] step);
    sample_t s;
    s.stamp = stamp;
    for (int i = 0; i < NUM_SIGNED; i++) s.chan[i] = value;
    s.chan[1] = fine;
    s.rev = rev;
    s.step = step;
    return s;
  endfunction

  function automatic sample_t random_sample(int unsigned bad_pct);
    sample_t s;
    case ($urandom_range(19))
      0: s.stamp = '1;
      1: s.stamp = '0;
      default: s.stamp = $urandom();
    endcase
    for (int i = 0; i < NUM_SIGNED; i++) s.chan[i] = pick16();
    if ($urandom_range(99) < bad_pct) s.chan[1] = pick16() | 16'h8000;
    else s.chan[1] = pick16() & 16'h7FFF;
    s.rev = pick16();
    case ($urandom_range(9))
      0: s.step = '1;
      1: s.step = '0;
      default: s.step = FAN_STEP_W'($urandom());
    endcase
    return s;
  endfunction

  task automatic offer(sample_t s);
    int gap;
    in_valid_i <= 1'b1;
    stamp_i <= s.stamp;
    pm_one_i <= s.chan[0];
    pm_fine_i <= s.chan[1];
    pm_four_i <= s.chan[2];
    pm_ten_i <= s.chan[3];
    humid_i <= s.chan[4];
    temper_i <= s.chan[5];
    voc_level_i <= s.chan[6];
    nox_level_i <= s.chan[7];
    fan_rev_i <= s.rev;
    fan_step_i <= s.step;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(s);
    sent++;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CNT_W-1:0] len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(mwa_pkg::REG_WINDOW));
    pwdata <= (DATA_W'($urandom()) & ~DATA_W'({CNT_W{1'b1}})) | DATA_W'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.length_reg = len;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned windows [NUM_PHASES];
    int unsigned bad_pcts [4];
    windows = '{1, 32, 63, 0, 2, 5, 17, 31, 1, 3, 8, 30};
    bad_pcts = '{15, 50, 90, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(fill(32'h0000_0010, 16'd100, 16'd7, 16'd100, 8'd10));
    offer(fill(32'h0000_0011, 16'hFED3, 16'hFFFF, 16'd999, 8'd99));
    wait_drained();
    cfg_write(CNT_W'(1));
    offer(fill(32'h0000_0012, 16'hFFFD, 16'd0, 16'd3, 8'd3));
    offer(fill(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF));
    offer(fill(32'h0000_0000, 16'h8000, 16'h0000, 16'h0000, 8'h00));
    offer(fill(32'h5555_AAAA, 16'h1234, 16'hFFFF, 16'd1234, 8'd12));
    offer(fill(32'hAAAA_5555, 16'h7FFF, 16'h8000, 16'hFFFF, 8'hFF));
    wait_drained();
    cfg_write(CNT_W'(0));
    offer(fill(32'h0000_0100, 16'h8001, 16'h0001, 16'h8000, 8'h80));
    wait_drained();
    cfg_write(CNT_W'(3));
    offer(fill(32'h0000_0200, 16'hFFFB, 16'd3, 16'd1, 8'd1));
    offer(fill(32'h0000_0201, 16'hFFFE, 16'hFFF0, 16'd7, 8'd7));
    offer(fill(32'h0000_0202, 16'hFFFC, 16'd0, 16'd2, 8'd2));
    wait_drained();
    cfg_write(CNT_W'(10));
    repeat (7) offer(random_sample(30));
    wait_drained();
    cfg_write(CNT_W'(3));
    offer(random_sample(30));
    wait_drained();
    cfg_write(CNT_W'(2));
    offer(fill(32'h0000_0300, 16'h4000, 16'hFFFF, 16'hFFFF, 8'hFF));
    offer(fill(32'h0000_0301, 16'h4000, 16'h8000, 16'hFFFF, 8'hFF));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 4)
        0: begin
          tx_idle = 20;
          rx_idle = 56;
        end
        1: begin
          tx_idle = 56;
          rx_idle = 20;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      wait_drained();
      cfg_write(CNT_W'(windows[ph]));
      if (ph == 8) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 9 && n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (board.due.size() != 0);
        end
        offer(random_sample(bad_pcts[ph % 4]));
      end
    end
    wait_drained();

    $display("Sent %0d samples over %0d window settings incl. 0, 1, 32 and 63;",
             sent, NUM_PHASES + 6);
    $display("checked %0d averaged records, %0d mismatches.", board.records,
             board.mismatches);
    if (board.mismatches == 0 && board.due.size() == 0) begin
      $display("multichannel_window_averager_test OK");
    end else begin
      $display("multichannel_window_averager_test NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mwa_pkg.sv
rtl/mwa_acc.sv
rtl/mwa_div.sv
rtl/multichannel_window_averager.sv
dv/multichannel_window_averager_test.sv
